/* sv/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, constants and helpers of the tensor axis sum reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

	localparam int MAX_DIM     = 64;
	localparam int SAMPLE_BITS = 32;

	localparam int SAMPLE_W = 32;
	localparam int TOTAL_W  = 40;
	localparam int DIM_W    = 7;
	localparam int CNT_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CMP_W    = (CNT_W > DIM_W) ? CNT_W : DIM_W;
	localparam int ADDR_W   = 2 * CNT_W;
	localparam int ACC_DEPTH = 1 << ADDR_W;

	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// register indexes on the config port
	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2,
		REG_AXIS     = 2'd3
	} reg_idx_t;

	// reduce axis codes; the unused code sums over channel
	typedef enum logic [1:0] {
		AXIS_CHAN   = 2'd0,
		AXIS_HEIGHT = 2'd1,
		AXIS_WIDTH  = 2'd2
	} axis_t;

	// per-beat tags travelling with the accumulator address
	typedef struct packed {
		logic first;   // first term of its sum
		logic done;    // completes its sum
		logic tail;    // last element of the tensor
	} tag_t;

	function automatic dim_t clamp_dim(input dim_t d);
		dim_t r;
		if (d == '0) begin
			r = dim_t'(1);
		end else if (int'(d) > MAX_DIM) begin
			r = dim_t'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/tsr_ram.sv */
// ----------------------------------------------------------------------------
// tsr_ram
// Generic simple dual port RAM, one write and one registered read port.
// Read during write to the same address returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/tsr_seq.sv */
// ----------------------------------------------------------------------------
// tsr_seq
// Position counters (channel fastest, then column, then row) and the
// accumulator address and sum tags of the beat on the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_seq import tsr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       restart,
	input  wire logic       accept,
	input  wire dim_t       width_q,
	input  wire dim_t       height_q,
	input  wire dim_t       chans_q,
	input  wire logic [1:0] axis_q,
	output addr_t           addr,
	output tag_t            tag
);

	cnt_t row_q, col_q, chan_q;
	dim_t wd_m1, ht_m1, ch_m1;
	logic row_end, col_end, chan_end;

	assign wd_m1 = clamp_dim(width_q) - dim_t'(1);
	assign ht_m1 = clamp_dim(height_q) - dim_t'(1);
	assign ch_m1 = clamp_dim(chans_q) - dim_t'(1);

	assign row_end  = (CMP_W'(row_q) == CMP_W'(ht_m1));
	assign col_end  = (CMP_W'(col_q) == CMP_W'(wd_m1));
	assign chan_end = (CMP_W'(chan_q) == CMP_W'(ch_m1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (restart) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (accept) begin
			if (chan_end) begin
				chan_q <= '0;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + cnt_t'(1);
				end else begin
					col_q <= col_q + cnt_t'(1);
				end
			end else begin
				chan_q <= chan_q + cnt_t'(1);
			end
		end
	end

	// {outer, channel} keeps every open sum in an entry of its own
	always_comb begin
		tag.tail = row_end && col_end && chan_end;
		unique case (axis_q)
			AXIS_WIDTH: begin
				addr      = {row_q, chan_q};
				tag.first = (col_q == '0);
				tag.done  = col_end;
			end
			AXIS_HEIGHT: begin
				addr      = {col_q, chan_q};
				tag.first = (row_q == '0);
				tag.done  = row_end;
			end
			default: begin
				addr      = '0;
				tag.first = (chan_q == '0);
				tag.done  = chan_end;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/tsr_accum.sv */
// ----------------------------------------------------------------------------
// tsr_accum
// Read-modify-write of the accumulator RAM with a forward register, and the
// output register for finished sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_accum import tsr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire addr_t               addr,
	input  wire tag_t                tag,
	output logic                     ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output total_t                   total,
	output logic                     last
);

	logic                    vld_q;
	addr_t                   addr_s1;
	tag_t                    tag_s1;
	total_t                  samp_s1;
	logic signed [SAMPLE_BITS-1:0] samp_low;

	logic                    wr_vld_q;
	addr_t                   wr_addr_q;
	total_t                  wr_sum_q;

	total_t                  rd_data;
	total_t                  base;
	total_t                  sum;
	logic                    adv;
	logic                    out_vld_q;
	total_t                  total_q;
	logic                    last_q;

	assign samp_low = sample[SAMPLE_BITS-1:0];

	// stage 1 retires when its result has a place to go
	assign adv   = vld_q && (!tag_s1.done || !out_vld_q || out_ready);
	assign ready = !vld_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ready) begin
			vld_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr;
			tag_s1  <= tag;
			samp_s1 <= TOTAL_W'(samp_low);
		end
	end

	tsr_ram #(
		.WIDTH (TOTAL_W),
		.DEPTH (ACC_DEPTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (addr_s1),
		.wdata (sum),
		.re    (accept),
		.raddr (addr),
		.rdata (rd_data)
	);

	// last write covers a write landing on the same edge as our read
	always_comb begin
		base = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_sum_q : rd_data;
		sum  = tag_s1.first ? samp_s1 : base + samp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (adv) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_addr_q <= addr_s1;
			wr_sum_q  <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && tag_s1.done) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s1.done) begin
			total_q <= sum;
			last_q  <= tag_s1.tail;
		end
	end

	assign out_valid = out_vld_q;
	assign total     = total_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* sv/tensor_axis_sum_reduce.sv */
// ----------------------------------------------------------------------------
// tensor_axis_sum_reduce
// Streaming sum of an H x W x C tensor along one axis, exact Q24.16 totals.
// ----------------------------------------------------------------------------
// Output: a finished sum passes the stage 1 register, then the output register.
// Throughput: one beat per cycle unless a held result stalls the input, set by
//   one RAM read-modify-write per beat; a forward register covers back to back.
// Reset: counters, handshake clear, config to 1x1x1; accumulator RAM is not
//   cleared and needs no pass, since the first term of every sum overwrites.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_axis_sum_reduce import tsr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// config write port
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [DIM_W-1:0]    cfg_data,
	// input beats
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] sample,
	// result beats
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [TOTAL_W-1:0]       total,
	output logic                     last
);

	dim_t       width_q, height_q, chans_q;
	logic [1:0] axis_q;
	logic       accept;
	addr_t      addr;
	tag_t       tag;

	// config registers; any write also restarts the tensor position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dim_t'(1);
			height_q <= dim_t'(1);
			chans_q  <= dim_t'(1);
			axis_q   <= AXIS_CHAN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_CHANNELS: chans_q  <= cfg_data;
				REG_AXIS:     axis_q   <= cfg_data[1:0];
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	// address and tags for the beat being offered
	tsr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.accept   (accept),
		.width_q  (width_q),
		.height_q (height_q),
		.chans_q  (chans_q),
		.axis_q   (axis_q),
		.addr     (addr),
		.tag      (tag)
	);

	// RAM read on accept; stage 1 adds and writes back when it retires
	tsr_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (sample),
		.addr      (addr),
		.tag       (tag),
		.ready     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.total     (total),
		.last      (last)
	);

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a held result");

	// end of tensor always completes a sum
	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		tag.tail |-> tag.done)
		else $error("tensor end without a finished sum");

	// channel reduction keeps a single running sum
	a_chan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(axis_q != AXIS_WIDTH && axis_q != AXIS_HEIGHT) |-> (addr == '0))
		else $error("channel reduction off entry zero");

endmodule

`default_nettype wire

/* tb/tensor_axis_sum_reduce_tb.sv */
// ----------------------------------------------------------------------------
// tensor_axis_sum_reduce_tb
// Self-checking bench for the streaming axis sum reducer. A queue-fed driver
// sends sample beats in random bursts. A local model of the accumulator store
// and position counters predicts every finished sum. A monitor with its own
// stall pattern checks total and last against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tensor_axis_sum_reduce_tb;
	import tsr_pkg::*;

	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic               last;
	} sum_beat_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [1:0]          cfg_index = REG_WIDTH;
	logic [DIM_W-1:0]    cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample    = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [TOTAL_W-1:0]  total;
	logic                last;

	tensor_axis_sum_reduce u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.total     (total),
		.last      (last)
	);

	always #6 clk = ~clk;

	// sample beats waiting to be driven, finished sums waiting to be seen
	logic [SAMPLE_W-1:0] sample_q[$];
	sum_beat_t           sum_q[$];
	int                  errors = 0;

	// shadow of the block: registers, counters, partial sums
	logic [DIM_W-1:0]         width_reg, height_reg, chan_reg;
	logic [1:0]               axis_reg;
	int unsigned              row_pos, col_pos, chan_pos;
	logic signed [TOTAL_W-1:0] part_sum [ACC_DEPTH];

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return 32'(d);
	endfunction

	// add one sample into its partial sum; queue the total if it completes
	task automatic accumulate(input logic [SAMPLE_W-1:0] smp);
		int unsigned               wd, ht, ch, slot;
		bit                        opens, closes, tensor_end;
		logic signed [TOTAL_W-1:0] term, acc;
		sum_beat_t                 beat;
		wd = eff_dim(width_reg);
		ht = eff_dim(height_reg);
		ch = eff_dim(chan_reg);
		term = {{(TOTAL_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
		case (axis_reg)
			AXIS_WIDTH: begin
				slot   = row_pos * ch + chan_pos;
				opens  = (col_pos == 0);
				closes = (col_pos == wd - 1);
			end
			AXIS_HEIGHT: begin
				slot   = col_pos * ch + chan_pos;
				opens  = (row_pos == 0);
				closes = (row_pos == ht - 1);
			end
			default: begin
				slot   = 0;
				opens  = (chan_pos == 0);
				closes = (chan_pos == ch - 1);
			end
		endcase
		acc = opens ? term : part_sum[slot] + term;
		part_sum[slot] = acc;
		tensor_end = (row_pos == ht - 1) && (col_pos == wd - 1) && (chan_pos == ch - 1);
		// channel fastest, then column, then row
		chan_pos++;
		if (chan_pos >= ch) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= wd) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= ht)
					row_pos = 0;
			end
		end
		if (closes) begin
			beat.total = acc;
			beat.last  = tensor_end;
			sum_q.push_back(beat);
		end
	endtask

	// ---- driver: bursts of beats with random gaps ----
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			sample     <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && in_ready)
				accumulate(sample);
			// a beat still waiting for ready is held as it is
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 40);
					in_valid <= 1'b1;
					sample   <= sample_q.pop_front();
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor: checks sums, stalls on four ready patterns in turn ----
	int unsigned mon_cycle = 0;

	always @(posedge clk or negedge arst_n) begin
		sum_beat_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			mon_cycle = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sum_q.size() == 0) begin
					$display("%0t: unexpected sum beat, expected none, actual total=%h last=%b",
						$time, total, last);
					errors++;
				end else begin
					want = sum_q.pop_front();
					if (total !== want.total) begin
						$display("%0t: total mismatch, expected %h, actual %h",
							$time, want.total, total);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch, expected %b, actual %b",
							$time, want.last, last);
						errors++;
					end
				end
			end
			mon_cycle++;
			case ((mon_cycle >> 8) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (mon_cycle[2:0] != 3'd0);
			endcase
		end
	end

	// ---- stimulus helpers ----
	task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_WIDTH:    width_reg  = val;
			REG_HEIGHT:   height_reg = val;
			REG_CHANNELS: chan_reg   = val;
			default:      axis_reg   = val[1:0];
		endcase
		row_pos  = 0;
		col_pos  = 0;
		chan_pos = 0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] c, input logic [DIM_W-1:0] ax);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_CHANNELS, c);
		write_reg(REG_AXIS, ax);
	endtask

	// all beats taken, all sums seen, then a settle for beats that end no sum
	task automatic drain();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || in_valid || sum_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 511) - 256;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return '0;
		if (k == 1)
			return DIM_W'($urandom_range(65, 127));
		if (k == 2)
			return 7'd64;
		return DIM_W'($urandom_range(1, 6));
	endfunction

	initial begin
		int                n_rand, beats, cells;
		logic [DIM_W-1:0]  w, h, c;
		logic [1:0]        ax;

		width_reg  = 7'd1;
		height_reg = 7'd1;
		chan_reg   = 7'd1;
		axis_reg   = AXIS_CHAN;
		row_pos    = 0;
		col_pos    = 0;
		chan_pos   = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset shape 1x1x1: every beat is a whole tensor
		sample_q.push_back(32'h7FFF_FFFF);
		sample_q.push_back(32'h8000_0000);
		sample_q.push_back(32'h0000_0000);
		sample_q.push_back(32'hFFFF_FFFF);
		drain();

		// small shapes on the width and height axes, through tensor end and wrap
		set_shape(7'd3, 7'd2, 7'd2, DIM_W'(AXIS_WIDTH));
		repeat (12) sample_q.push_back(rand_sample());
		drain();
		set_shape(7'd2, 7'd3, 7'd1, DIM_W'(AXIS_HEIGHT));
		repeat (6) sample_q.push_back(rand_sample());
		drain();

		// 64 extreme terms in one sum; zero dims act as 1, oversize as 64
		set_shape(7'd0, 7'd0, 7'd127, DIM_W'(AXIS_CHAN));
		repeat (64) sample_q.push_back(32'h7FFF_FFFF);
		repeat (64) sample_q.push_back(32'h8000_0000);
		drain();

		// all 64 columns on the height axis: each column slot opened and read back
		set_shape(7'd64, 7'd2, 7'd4, DIM_W'(AXIS_HEIGHT));
		repeat (2 * 64 * 4) sample_q.push_back(rand_sample());
		drain();

		// random shapes, axis codes and tensor counts; partial tensors get cut
		// off by the next register write
		n_rand = 0;
		while (n_rand < 450) begin
			do begin
				w = rand_dim();
				h = rand_dim();
				c = rand_dim();
				cells = eff_dim(w) * eff_dim(h) * eff_dim(c);
			end while (cells > 256);
			ax = 2'($urandom_range(0, 3));
			set_shape(w, h, c, {5'($urandom_range(0, 31)), ax});
			beats = cells * $urandom_range(1, 3);
			if ($urandom_range(0, 2) == 0)
				beats += $urandom_range(0, cells - 1);
			repeat (beats) sample_q.push_back(rand_sample());
			n_rand += beats;
			drain();
		end

		repeat (16) @(negedge clk);
		if (errors == 0 && sum_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/tsr_pkg.sv
sv/tsr_ram.sv
sv/tsr_seq.sv
sv/tsr_accum.sv
sv/tensor_axis_sum_reduce.sv
tb/tensor_axis_sum_reduce_tb.sv
